[src/partition_fit_allocator_top_defines.svh]
// Assertion macros for the allocator RTL.
`ifndef PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PFA_ASSERT(label, prop, msg) \
  `PFA_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define PFA_ASSERT_CLK(label, clock, reset, prop, msg)
`define PFA_ASSERT(label, prop, msg)
`endif
`endif

[src/pfa_pkg.sv]
// Types and constants shared by the allocator modules.
`default_nettype none
package pfa_pkg;
  localparam int FUNC_W      = 1;
  localparam int INDEX_W     = 6;
  localparam int SIZE_W      = 16;
  localparam int POLICY_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FIRST = 3'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 3'd2;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_LAST  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_POLICY      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

  // Control of the block table ports.
  typedef struct packed {
    logic rd_en;
    logic wr_loaded;
    logic wr_remaining;
  } mem_ctl_t;
endpackage
`default_nettype wire

[src/pfa_ifs.sv]
// Request and result channel interfaces of the allocator.
`default_nettype none
interface pfa_req_if;
  logic                         valid;
  logic                         ready;
  logic [pfa_pkg::FUNC_W-1:0]   func;
  logic [pfa_pkg::INDEX_W-1:0]  entry_index;
  logic [pfa_pkg::SIZE_W-1:0]   size;
  modport source (output valid, output func, output entry_index, output size, input ready);
  modport sink (input valid, input func, input entry_index, input size, output ready);
endinterface

interface pfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [pfa_pkg::INDEX_W-1:0]  chosen_index;
  logic [pfa_pkg::SIZE_W-1:0]   block_size;
  modport source (output valid, output granted, output chosen_index, output block_size,
                  input ready);
  modport sink (input valid, input granted, input chosen_index, input block_size,
                output ready);
endinterface
`default_nettype wire

[src/pfa_table.sv]
// Block table: loaded and remaining size memories with registered reads.
`default_nettype none
module pfa_table #(
  parameter int NUM_BLOCKS = 64,
  parameter int SIZE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire pfa_pkg::mem_ctl_t       ctl,
  input  wire logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] rd_addr,
  input  wire logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] wr_addr,
  input  wire logic [SIZE_WIDTH-1:0]   wr_data,
  output logic      [SIZE_WIDTH-1:0]   rd_loaded,
  output logic      [SIZE_WIDTH-1:0]   rd_remaining
);
  logic [SIZE_WIDTH-1:0] loaded_mem    [NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0] remaining_mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (ctl.wr_loaded) begin
      loaded_mem[wr_addr] <= wr_data;
    end
    if (ctl.wr_remaining) begin
      remaining_mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_loaded    <= loaded_mem[rd_addr];
      rd_remaining <= remaining_mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[src/pfa_ctrl.sv]
// Request sequencer: table loads, table scan, policy selection, write-back and result register.
`default_nettype none
`include "partition_fit_allocator_top_defines.svh"
module pfa_ctrl #(
  parameter int NUM_BLOCKS = 64,
  parameter int SIZE_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  pfa_req_if.sink                               in_ch,
  pfa_rsp_if.source                             out_ch,
  input  wire logic [pfa_pkg::POLICY_W-1:0]     policy,
  input  wire logic [pfa_pkg::COUNT_W-1:0]      block_count,
  output pfa_pkg::mem_ctl_t                     mem_ctl,
  output logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] rd_addr,
  output logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] wr_addr,
  output logic [SIZE_WIDTH-1:0]                 wr_data,
  input  wire logic [SIZE_WIDTH-1:0]            rd_loaded,
  input  wire logic [SIZE_WIDTH-1:0]            rd_remaining
);
  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]                  state, state_next;
  logic [IW-1:0]               cnt;
  logic [CW-1:0]               n_q;
  logic [SIZE_WIDTH-1:0]       sz_q;
  logic [pfa_pkg::POLICY_W-1:0] pol_q;
  logic [IW-1:0]               start;
  logic [IW-1:0]               ptr;
  logic                        rv;
  logic [IW-1:0]               ridx;
  logic                        found_a, found_b;
  logic [IW-1:0]               pick_a, pick_b, pick;
  logic [SIZE_WIDTH-1:0]       rem_a;
  logic                        out_valid;
  logic                        out_granted;
  logic [pfa_pkg::INDEX_W-1:0] out_index;
  logic [pfa_pkg::SIZE_W-1:0]  out_size;

  logic                        accept, load_ok, slot_free;
  logic [31:0]                 size32, idx32, bc32, n32, pick32, ld32;
  logic [SIZE_WIDTH-1:0]       in_sz;
  logic [IW-1:0]               in_addr;
  logic [CW-1:0]               n_eff;
  logic                        fit, take_a, take_b;
  logic                        fin_found;
  logic [IW-1:0]               fin_pick;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;
  assign size32    = 32'(in_ch.size);
  assign in_sz     = size32[SIZE_WIDTH-1:0];
  assign idx32     = 32'(in_ch.entry_index);
  assign in_addr   = idx32[IW-1:0];
  assign load_ok   = accept && (in_ch.func == pfa_pkg::FUNC_LOAD) &&
                     (idx32 < 32'(NUM_BLOCKS));
  assign bc32      = 32'(block_count);
  assign n32       = (bc32 > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : bc32;
  assign n_eff     = n32[CW-1:0];
  assign pick32    = 32'(pick);
  assign ld32      = 32'(rd_loaded);

  // Scan evaluation on the entry whose read data arrived this cycle.
  always_comb begin
    fit    = rd_remaining >= sz_q;
    take_a = 1'b0;
    take_b = 1'b0;
    if (rv) begin
      case (pol_q)
        pfa_pkg::POL_FIRST: take_a = fit && !found_a;
        pfa_pkg::POL_BEST:  take_a = fit && (!found_a || rd_remaining < rem_a);
        pfa_pkg::POL_WORST: take_a = fit && (!found_a || rd_remaining > rem_a);
        pfa_pkg::POL_NEXT: begin
          // The circular scan is split into the part from the pointer upward
          // and the wrapped part below it; the upper part wins.
          if (ridx >= start) begin
            take_a = fit && !found_a;
          end else begin
            take_b = fit && !found_b;
          end
        end
        pfa_pkg::POL_LAST:  take_a = fit;
        default: begin
          take_a = 1'b0;
          take_b = 1'b0;
        end
      endcase
    end
  end

  assign fin_found = found_a || found_b;
  assign fin_pick  = found_a ? pick_a : pick_b;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_ch.func == pfa_pkg::FUNC_ALLOC)) begin
          if ((n_eff == '0) || (policy > pfa_pkg::POL_LAST)) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (32'(cnt) + 32'd1 >= 32'(n_q)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_PICK;
      S_PICK:  state_next = fin_found ? S_WRITE : S_RESULT;
      S_WRITE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl.rd_en        = (state == S_SCAN) || ((state == S_PICK) && fin_found);
    mem_ctl.wr_loaded    = load_ok;
    mem_ctl.wr_remaining = load_ok || ((state == S_WRITE) && slot_free);
    rd_addr              = (state == S_SCAN) ? cnt : fin_pick;
    wr_addr              = (state == S_WRITE) ? pick : in_addr;
    wr_data              = (state == S_WRITE) ? (rd_remaining - sz_q) : in_sz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == S_SCAN);
      if (load_ok) begin
        ptr <= '0;
      end else if ((state == S_WRITE) && slot_free && (pol_q == pfa_pkg::POL_NEXT)) begin
        ptr <= pick;
      end
      if (((state == S_WRITE) || (state == S_RESULT)) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt     <= '0;
      n_q     <= n_eff;
      sz_q    <= in_sz;
      pol_q   <= policy;
      start   <= (32'(ptr) < n32) ? ptr : '0;
      found_a <= 1'b0;
      found_b <= 1'b0;
    end else begin
      if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
      end
      ridx <= cnt;
      if (take_a) begin
        found_a <= 1'b1;
        pick_a  <= ridx;
        rem_a   <= rd_remaining;
      end
      if (take_b) begin
        found_b <= 1'b1;
        pick_b  <= ridx;
      end
    end
    if (state == S_PICK) begin
      pick <= fin_pick;
    end
    if ((state == S_WRITE) && slot_free) begin
      out_granted <= 1'b1;
      out_index   <= pick32[pfa_pkg::INDEX_W-1:0];
      out_size    <= ld32[pfa_pkg::SIZE_W-1:0];
    end else if ((state == S_RESULT) && slot_free) begin
      out_granted <= 1'b0;
      out_index   <= '0;
      out_size    <= '0;
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.granted      = out_granted;
  assign out_ch.chosen_index = out_index;
  assign out_ch.block_size   = out_size;

  `PFA_ASSERT(a_scan_in_range, (state == S_SCAN) |-> (32'(cnt) < 32'(n_q)), "scan address past block count")
  `PFA_ASSERT(a_pick_in_range, (state == S_WRITE) |-> (32'(pick) < 32'(n_q)), "chosen block past block count")
  `PFA_ASSERT(a_grant_follows_write, ((state == S_WRITE) && slot_free) |=> (out_valid && out_granted), "write-back without granted result")
  `PFA_ASSERT(a_no_read_on_write, !(mem_ctl.rd_en && mem_ctl.wr_remaining), "table read and write in one cycle")
endmodule
`default_nettype wire

[src/partition_fit_allocator_top.sv]
// Top level of the partition fit allocator: configuration registers, sequencer, table.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          func, entry_index, size
//  out_ch    out  valid/ready          granted, chosen_index, block_size
//  cfg       in   cfg_we (no stall)    cfg_index, cfg_wdata
//
// A load request is written to the table in the cycle it is accepted; an allocate request
// reads the remaining-size memory one entry a cycle over the effective block count, then
// picks and writes back. Block count zero or an unknown policy skips the scan.
// Reset is synchronous; the table memories are not cleared and need no clearing pass.
// A finished result waits in the output register while the next request is accepted;
// an allocate that finds the register still full waits before its write-back.
`default_nettype none
module partition_fit_allocator_top #(
  parameter int NUM_BLOCKS = 64,
  parameter int SIZE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  pfa_req_if.sink                                  in_ch,
  pfa_rsp_if.source                                out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [pfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [pfa_pkg::POLICY_W-1:0] policy;
  logic [pfa_pkg::COUNT_W-1:0]  block_count;
  pfa_pkg::mem_ctl_t            mem_ctl;
  logic [IW-1:0]                rd_addr, wr_addr;
  logic [SIZE_WIDTH-1:0]        wr_data, rd_loaded, rd_remaining;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= pfa_pkg::POL_FIRST;
      block_count <= pfa_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfa_pkg::REG_POLICY:      policy      <= cfg_wdata[pfa_pkg::POLICY_W-1:0];
        pfa_pkg::REG_BLOCK_COUNT: block_count <= cfg_wdata[pfa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pfa_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .policy       (policy),
    .block_count  (block_count),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_loaded    (rd_loaded),
    .rd_remaining (rd_remaining)
  );

  pfa_table #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_table (
    .clk          (clk),
    .ctl          (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_loaded    (rd_loaded),
    .rd_remaining (rd_remaining)
  );
endmodule
`default_nettype wire
